// ----- design/cbse_pkg.sv -----
// Package with the shared types and constants of the cubic Bezier spline evaluator.
package cbse_pkg;

	localparam int MaxSegments = 64;
	localparam int SegW = $clog2(MaxSegments);
	localparam int CountW = 7;
	localparam int CoordW = 24;
	localparam int DerivW = 32;
	localparam int TW = 17;
	localparam int FracW = 16;
	localparam logic [TW-1:0] TOne = 17'h10000;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_T_RANGE = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [5:0] segment_index;
		logic [1:0] point_index;
		logic signed [CoordW-1:0] coord_x;
		logic signed [CoordW-1:0] coord_y;
		logic [TW-1:0] t_param;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] segment_used;
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [DerivW-1:0] tangent_x;
		logic signed [DerivW-1:0] tangent_y;
		logic signed [DerivW-1:0] accel_x;
		logic signed [DerivW-1:0] accel_y;
	} resp_t;

	// Classified job passed from the front part to the back part.
	typedef struct packed {
		logic eval;
		status_t status;
		logic [SegW-1:0] seg;
		logic [FracW:0] lt;
	} job_t;

endpackage

// ----- design/cbse_if.sv -----
// Valid/ready stream interfaces for requests and results.
interface cbse_req_if;
	import cbse_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cbse_resp_if;
	import cbse_pkg::*;
	logic valid;
	logic ready;
	resp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/cbse_front.sv -----
// Front part: accepts transactions, registers point writes and classifies evaluations.
module cbse_front import cbse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [CountW-1:0] seg_count,
	input logic in_valid,
	output logic in_ready,
	input req_t in_data,
	input logic q_ready,
	output logic q_valid,
	output job_t q_job,
	output logic [SegW-1:0] rd_seg,
	output logic [1:0] wr_pt,
	output logic [2*CoordW-1:0] wr_data
);
	logic valid_s1, adv;
	logic [CountW-1:0] n_s1;
	logic [TW-1:0] t_s1;
	logic eval_s1;
	logic [SegW-1:0] wseg_s1;
	logic [1:0] wpt_s1;
	logic [2*CoordW-1:0] wdata_s1;
	logic [TW+CountW-1:0] scaled;
	logic [CountW-1:0] n_clamp;
	logic [TW+CountW-FracW-1:0] idx_raw;
	logic [SegW-1:0] idx;
	logic [FracW:0] lt;

	assign in_ready = !valid_s1 || q_ready;
	assign adv = in_valid && in_ready;

	assign n_clamp = (seg_count > CountW'(MaxSegments)) ? CountW'(MaxSegments) : seg_count;

	// Stage one registers the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1 <= n_clamp;
			t_s1 <= in_data.t_param;
			eval_s1 <= in_data.req_type;
			wseg_s1 <= in_data.segment_index[SegW-1:0];
			wpt_s1 <= in_data.point_index;
			wdata_s1 <= {in_data.coord_y, in_data.coord_x};
		end
	end

	// Split t times the count into a segment and a local t.
	always_comb begin
		scaled = TW'(t_s1) * n_s1;
		idx_raw = scaled[TW+CountW-1:FracW];
		if (n_s1 != '0 && idx_raw >= (TW+CountW-FracW)'(n_s1))
			idx = SegW'(n_s1 - 1'b1);
		else
			idx = idx_raw[SegW-1:0];
		lt = (FracW+1)'(scaled - ((TW+CountW)'(idx) << FracW));
	end

	// Point writes travel with their transaction so that the store sees them in order.
	assign rd_seg = eval_s1 ? idx : wseg_s1;
	assign wr_pt = wpt_s1;
	assign wr_data = wdata_s1;
	assign q_valid = valid_s1;
	always_comb begin
		q_job.eval = eval_s1;
		q_job.seg = idx;
		q_job.lt = lt;
		if (!eval_s1) q_job.status = ST_OK;
		else if (t_s1 > TOne) q_job.status = ST_T_RANGE;
		else if (n_s1 == '0) q_job.status = ST_EMPTY;
		else q_job.status = ST_OK;
	end
endmodule

// ----- design/cbse_back.sv -----
// Back part: point store and pipelined de Casteljau evaluation.
module cbse_back import cbse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input job_t job,
	input logic [SegW-1:0] rd_seg,
	input logic wr_en,
	input logic [1:0] wr_pt,
	input logic [SegW-1:0] wr_seg,
	input logic [2*CoordW-1:0] wr_data,
	cbse_resp_if.source resp
);
	localparam int NS = 6;
	typedef logic signed [CoordW-1:0] crd_t;
	typedef logic signed [CoordW+1:0] dif_t;

	logic [2*CoordW-1:0] mem0 [MaxSegments];
	logic [2*CoordW-1:0] mem1 [MaxSegments];
	logic [2*CoordW-1:0] mem2 [MaxSegments];
	logic [2*CoordW-1:0] mem3 [MaxSegments];
	logic [2*CoordW-1:0] rd0, rd1, rd2, rd3;

	logic [NS-1:0] v;
	job_t j [NS];
	logic stall, adv;

	// Point store, read data registered into stage one.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (wr_pt)
				2'd0: mem0[wr_seg] <= wr_data;
				2'd1: mem1[wr_seg] <= wr_data;
				2'd2: mem2[wr_seg] <= wr_data;
				default: mem3[wr_seg] <= wr_data;
			endcase
		end
		if (adv) begin
			rd0 <= mem0[rd_seg];
			rd1 <= mem1[rd_seg];
			rd2 <= mem2[rd_seg];
			rd3 <= mem3[rd_seg];
		end
	end

	// The pipeline moves as one; it stalls when the last stage cannot leave.
	assign stall = v[NS-1] && resp.valid && !resp.ready;
	assign adv = !stall;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (adv) begin
			v <= {v[NS-2:0], in_valid};
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			j[0] <= job;
			for (int i = 1; i < NS; i++) j[i] <= j[i-1];
		end
	end

	// Lerp on one pair; the product is registered by the caller.
	function automatic logic signed [CoordW+FracW+1:0] lmul(crd_t a, crd_t b,
			logic [FracW:0] t);
		logic signed [FracW+1:0] ts, tc;
		ts = $signed({1'b0, t});
		tc = $signed({1'b0, TOne}) - ts;
		return (CoordW+FracW+2)'(tc * a) + (CoordW+FracW+2)'(ts * b);
	endfunction

	crd_t p_s1 [2][4];
	crd_t a_s2 [2][3];
	crd_t b_s3 [2][2];
	crd_t b_s4 [2][2];
	crd_t c_s5 [2];
	logic signed [DerivW-1:0] tan_s4 [2], tan_s5 [2];
	logic signed [CoordW+FracW+1:0] m2 [2][3], m3 [2][2], m5 [2];
	dif_t d1_s2 [2], d2_s2 [2];
	logic signed [CoordW+FracW+4:0] am_s3 [2];
	logic signed [DerivW-1:0] acc_s4 [2], acc_s5 [2];
	resp_t res_d;

	always_comb begin
		p_s1[0][0] = rd0[CoordW-1:0]; p_s1[1][0] = rd0[2*CoordW-1:CoordW];
		p_s1[0][1] = rd1[CoordW-1:0]; p_s1[1][1] = rd1[2*CoordW-1:CoordW];
		p_s1[0][2] = rd2[CoordW-1:0]; p_s1[1][2] = rd2[2*CoordW-1:CoordW];
		p_s1[0][3] = rd3[CoordW-1:0]; p_s1[1][3] = rd3[2*CoordW-1:CoordW];
	end

	// Stages two to five: de Casteljau levels, the tangent and the second derivative.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 2; k++) begin
				for (int i = 0; i < 3; i++)
					m2[k][i] <= lmul(p_s1[k][i], p_s1[k][i+1], j[0].lt);
				d1_s2[k] <= dif_t'(p_s1[k][2]) - dif_t'(2) * dif_t'(p_s1[k][1])
					+ dif_t'(p_s1[k][0]);
				d2_s2[k] <= dif_t'(p_s1[k][3]) - dif_t'(2) * dif_t'(p_s1[k][2])
					+ dif_t'(p_s1[k][1]);
				for (int i = 0; i < 2; i++)
					m3[k][i] <= lmul(a_s2[k][i], a_s2[k][i+1], j[1].lt);
				am_s3[k] <= (CoordW+FracW+5)'(($signed({1'b0, TOne})
					- $signed({1'b0, j[1].lt})) * d1_s2[k])
					+ (CoordW+FracW+5)'($signed({1'b0, j[1].lt}) * d2_s2[k]);
				b_s4[k] <= b_s3[k];
				tan_s4[k] <= DerivW'(3 * (DerivW'(b_s3[k][1]) - DerivW'(b_s3[k][0])));
				acc_s4[k] <= DerivW'((6 * (CoordW+FracW+8)'(am_s3[k])) >>> FracW);
				m5[k] <= lmul(b_s4[k][0], b_s4[k][1], j[3].lt);
				tan_s5[k] <= tan_s4[k];
				acc_s5[k] <= acc_s4[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			for (int i = 0; i < 3; i++) a_s2[k][i] = crd_t'(m2[k][i] >>> FracW);
			for (int i = 0; i < 2; i++) b_s3[k][i] = crd_t'(m3[k][i] >>> FracW);
			c_s5[k] = crd_t'(m5[k] >>> FracW);
		end
	end

	// Result assembly; writes and rejected evaluations carry only the status.
	always_comb begin
		res_d = '0;
		res_d.status = j[4].status;
		if (j[4].eval && j[4].status == ST_OK) begin
			res_d.segment_used = 6'(j[4].seg);
			res_d.pos_x = c_s5[0];
			res_d.pos_y = c_s5[1];
			res_d.tangent_x = tan_s5[0];
			res_d.tangent_y = tan_s5[1];
			res_d.accel_x = acc_s5[0];
			res_d.accel_y = acc_s5[1];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp.valid <= 1'b0;
		end else if (adv) begin
			resp.valid <= v[NS-2];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			resp.data <= res_d;
		end
	end
endmodule

// ----- design/cubic_bezier_spline_eval.sv -----
// Throughput: one transaction per cycle; the back pipeline stalls only while a result waits.
// Reset clears the segment count and all valid flags; the point store is
// not cleared and holds undefined data until written.
// Top level of the cubic Bezier spline evaluator.
module cubic_bezier_spline_eval import cbse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CountW-1:0] cfg_wdata,
	cbse_req_if.sink req,
	cbse_resp_if.source resp
);
	logic [CountW-1:0] seg_count_q;
	logic q_valid, q_ready, b_valid, b_ready;
	job_t q_job, b_job;
	logic [SegW-1:0] rd_seg, b_seg;
	logic wr_en;
	logic [1:0] wr_pt, b_pt;
	logic [2*CoordW-1:0] wr_data, b_wdata;

	// Segment count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seg_count_q <= '0;
		else if (cfg_we) seg_count_q <= cfg_wdata;
	end

	cbse_front u_front (.clk, .arst_n, .seg_count(seg_count_q),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.q_ready, .q_valid, .q_job, .rd_seg, .wr_pt, .wr_data);

	// One-entry skid between front and back.
	logic sk_v_q;
	job_t sk_job_q;
	logic [SegW-1:0] sk_seg_q;
	logic [1:0] sk_pt_q;
	logic [2*CoordW-1:0] sk_wdata_q;
	assign q_ready = !sk_v_q;
	assign b_valid = sk_v_q || q_valid;
	assign b_job = sk_v_q ? sk_job_q : q_job;
	assign b_seg = sk_v_q ? sk_seg_q : rd_seg;
	assign b_pt = sk_v_q ? sk_pt_q : wr_pt;
	assign b_wdata = sk_v_q ? sk_wdata_q : wr_data;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sk_v_q <= 1'b0;
		else if (b_ready) sk_v_q <= 1'b0;
		else if (q_valid) sk_v_q <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (!sk_v_q) begin
			sk_job_q <= q_job;
			sk_seg_q <= rd_seg;
			sk_pt_q <= wr_pt;
			sk_wdata_q <= wr_data;
		end
	end

	// A point write reaches the store as its transaction enters the back part.
	assign wr_en = b_valid && b_ready && !b_job.eval;

	cbse_back u_back (.clk, .arst_n, .in_valid(b_valid), .in_ready(b_ready),
		.job(b_job), .rd_seg(b_seg), .wr_en, .wr_pt(b_pt), .wr_seg(b_seg),
		.wr_data(b_wdata), .resp);
endmodule

// ----- design/cbse_checker.sv -----
// Port checker for the spline evaluator, bound to the top level.
module cbse_checker import cbse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input resp_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status code");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.pos_x == '0
		&& out_data.segment_used == '0)
		else $error("error result carries data");
endmodule

bind cubic_bezier_spline_eval cbse_checker u_chk (.clk, .arst_n,
	.out_valid(resp.valid), .out_ready(resp.ready), .out_data(resp.data));
